// ===== sv/ptw_pkg.sv =====
// shared types, sizes and codes of the sv39 page table walker
// used by ptw_store, ptw_alu and sv39_page_table_walker; no dependencies
`default_nettype none

package ptw_pkg;

   // store geometry
   localparam int TABLE_PAGES       = 8;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int PAGE_W            = $clog2(TABLE_PAGES);
   localparam int ADDR_W            = PAGE_W + IDX_W;
   localparam int DEPTH             = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int NFP_W             = $clog2(TABLE_PAGES + 1);

   // entry and address fields
   localparam int PG_SHIFT = 12;
   localparam int PPN_W    = 44;
   localparam int FLAG_W   = 10;
   localparam int PTE_W    = PPN_W + FLAG_W;
   localparam int VA_W     = 39;
   localparam int PA_W     = 56;
   localparam int VPN_W    = VA_W - PG_SHIFT;
   localparam int LVL_W    = 2;

   // flag bit positions
   localparam int FLAG_V = 0;
   localparam int FLAG_R = 1;
   localparam int FLAG_X = 3;

   // flags of a pointer entry: valid only
   localparam logic [FLAG_W-1:0] FLAGS_PTR = FLAG_W'(1);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOTFOUND = 3'd1,
      ST_MISALIGN = 3'd2,
      ST_CONFLICT = 3'd3,
      ST_NOPAGES  = 3'd4,
      ST_OUTSIDE  = 3'd5
   } status_type;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_MAP    = 1'b1
   } req_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // one access of the entry store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PTE_W-1:0]  wdata;
   } mem_req_type;

   // request and result of the shared page number unit
   typedef struct packed {
      alu_op_type       op;
      logic [PPN_W-1:0] a;
      logic [PPN_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [PPN_W-1:0] sum;
      logic             in_store;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== sv/ptw_store.sv =====
// single port store of page table entries, registered read data
// depends on ptw_pkg
`default_nettype none

module ptw_store (
   input  wire logic                         clock,
   input  wire ptw_pkg::mem_req_type         mem_req,
   output logic [ptw_pkg::PTE_W-1:0]         rd_data
);

   logic [ptw_pkg::PTE_W-1:0] mem_ff [ptw_pkg::DEPTH];
   logic [ptw_pkg::PTE_W-1:0] rd_data_ff;

   // one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ptw_alu.sv =====
// shared 44-bit page number adder/subtractor with store range check
// depends on ptw_pkg
`default_nettype none

module ptw_alu (
   input  wire ptw_pkg::alu_req_type alu_req,
   output ptw_pkg::alu_res_type      alu_res
);

   logic [ptw_pkg::PPN_W-1:0] b_opnd;
   logic [ptw_pkg::PPN_W-1:0] sum;

   // a + b, or a - b modulo 2^44
   always_comb begin
      b_opnd = (alu_req.op == ptw_pkg::ALU_SUB) ? ~alu_req.b : alu_req.b;
      sum    = alu_req.a + b_opnd
             + ptw_pkg::PPN_W'(alu_req.op == ptw_pkg::ALU_SUB);
   end

   // relative page number lies inside the store
   assign alu_res.sum      = sum;
   assign alu_res.in_store = (sum < ptw_pkg::PPN_W'(ptw_pkg::TABLE_PAGES));

endmodule

`default_nettype wire

// ===== sv/sv39_page_table_walker.sv =====
// sv39 three-level page table walker over a local store of table pages
// lookup: a read and an evaluation step per level; map adds clearing and linking of each new table and a leaf write
// a misaligned map answers in the next cycle, from idle; a new item is taken in the cycle its result shows
// one item at a time: a new item waits until the result of the last one shows
// reset: synchronous; a clearing pass over all TABLE_PAGES*512 (4096) entries holds busy high
// results show for one cycle on rsp_valid; the receiver cannot stall
`default_nettype none

module sv39_page_table_walker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [ptw_pkg::VA_W-1:0]      req_virt_addr,
   input  wire logic [ptw_pkg::PA_W-1:0]      req_phys_addr,
   input  wire logic [ptw_pkg::FLAG_W-1:0]    req_perm_flags,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [ptw_pkg::PTE_W-1:0]          rsp_pte_value,
   output logic [ptw_pkg::LVL_W-1:0]          rsp_found_level,
   input  wire logic                          csr_wr_en,
   input  wire logic [ptw_pkg::PPN_W-1:0]     csr_table_base_ppn
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_ZERO  = 7'b0010000,
      S_LINK  = 7'b0100000,
      S_LEAF  = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [ptw_pkg::LVL_W-1:0]       level_ff, level_in;
   logic [ptw_pkg::PAGE_W-1:0]      page_ff, page_in;
   logic [ptw_pkg::NFP_W-1:0]       nfp_ff, nfp_in;
   logic [ptw_pkg::ADDR_W-1:0]      sweep_ff, sweep_in;
   logic [ptw_pkg::PPN_W-1:0]       base_ff;
   ptw_pkg::req_kind_type           op_ff;
   logic [ptw_pkg::VPN_W-1:0]       vpn_ff;
   logic [ptw_pkg::PPN_W-1:0]       pa_ppn_ff;
   logic [ptw_pkg::FLAG_W-1:0]      perm_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   ptw_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [ptw_pkg::PTE_W-1:0]       rsp_pte_ff, rsp_pte_in;
   logic [ptw_pkg::LVL_W-1:0]       rsp_level_ff, rsp_level_in;

   ptw_pkg::mem_req_type            mem_req;
   logic [ptw_pkg::PTE_W-1:0]       rd_data;
   ptw_pkg::alu_req_type            alu_req;
   ptw_pkg::alu_res_type            alu_res;

   logic [ptw_pkg::IDX_W-1:0]       idx;
   logic [ptw_pkg::PAGE_W-1:0]      new_page;
   logic                            misaligned;
   logic                            ent_v;
   logic                            ent_rwx;
   logic [ptw_pkg::PTE_W-1:0]       leaf_pte;

   ptw_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ptw_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // vpn slice of the current level
   always_comb begin
      case (level_ff)
         2'd2:    idx = vpn_ff[3*ptw_pkg::IDX_W-1:2*ptw_pkg::IDX_W];
         2'd1:    idx = vpn_ff[2*ptw_pkg::IDX_W-1:ptw_pkg::IDX_W];
         default: idx = vpn_ff[ptw_pkg::IDX_W-1:0];
      endcase
   end

   assign new_page   = nfp_ff[ptw_pkg::PAGE_W-1:0];
   assign misaligned = (req_virt_addr[ptw_pkg::PG_SHIFT-1:0] != '0)
                     || (req_phys_addr[ptw_pkg::PG_SHIFT-1:0] != '0);
   assign ent_v      = rd_data[ptw_pkg::FLAG_V];
   assign ent_rwx    = |rd_data[ptw_pkg::FLAG_X:ptw_pkg::FLAG_R];
   assign leaf_pte   = {pa_ppn_ff, perm_ff | ptw_pkg::FLAGS_PTR};

   // walk sequencer
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      nfp_in        = nfp_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pte_in    = rsp_pte_ff;
      rsp_level_in  = rsp_level_ff;
      mem_req.we    = 1'b0;
      mem_req.addr  = {page_ff, idx};
      mem_req.wdata = '0;
      alu_req.op    = ptw_pkg::ALU_SUB;
      alu_req.a     = rd_data[ptw_pkg::PTE_W-1:ptw_pkg::FLAG_W];
      alu_req.b     = base_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = sweep_ff;
            if (sweep_ff == ptw_pkg::ADDR_W'(ptw_pkg::DEPTH - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               if ((req_type == ptw_pkg::REQ_MAP) && misaligned) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ptw_pkg::ST_MISALIGN;
                  rsp_pte_in    = '0;
                  rsp_level_in  = '0;
               end else begin
                  level_in = 2'd2;
                  page_in  = '0;
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            if (level_ff == 2'd0) begin
               // bottom level: lookup returns the entry, map writes a leaf unless a valid leaf is there (conflict)
               if ((op_ff == ptw_pkg::REQ_MAP) && !(ent_v && ent_rwx)) begin
                  state_in = S_LEAF;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_ff == ptw_pkg::REQ_MAP) ? ptw_pkg::ST_CONFLICT
                                                              : ptw_pkg::ST_OK;
                  rsp_pte_in    = rd_data;
                  rsp_level_in  = '0;
                  state_in      = S_IDLE;
               end
            end else if (!ent_v) begin
               if (op_ff == ptw_pkg::REQ_LOOKUP) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ptw_pkg::ST_NOTFOUND;
                  rsp_pte_in    = '0;
                  rsp_level_in  = '0;
                  state_in      = S_IDLE;
               end else if (nfp_ff >= ptw_pkg::NFP_W'(ptw_pkg::TABLE_PAGES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ptw_pkg::ST_NOPAGES;
                  rsp_pte_in    = '0;
                  rsp_level_in  = '0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ZERO;
               end
            end else if (ent_rwx) begin
               // upper leaf: hit for lookup, conflict for map
               rsp_valid_in  = 1'b1;
               rsp_status_in = (op_ff == ptw_pkg::REQ_MAP) ? ptw_pkg::ST_CONFLICT
                                                           : ptw_pkg::ST_OK;
               rsp_pte_in    = rd_data;
               rsp_level_in  = level_ff;
               state_in      = S_IDLE;
            end else if (!alu_res.in_store) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptw_pkg::ST_OUTSIDE;
               rsp_pte_in    = '0;
               rsp_level_in  = '0;
               state_in      = S_IDLE;
            end else begin
               page_in  = alu_res.sum[ptw_pkg::PAGE_W-1:0];
               level_in = level_ff - 1'b1;
               state_in = S_READ;
            end
         end

         S_ZERO: begin
            // clear the freshly allocated table, one entry a cycle
            mem_req.we   = 1'b1;
            mem_req.addr = {new_page, sweep_ff[ptw_pkg::IDX_W-1:0]};
            if (sweep_ff[ptw_pkg::IDX_W-1:0]
                == ptw_pkg::IDX_W'(ptw_pkg::ENTRIES_PER_TABLE - 1)) begin
               sweep_in = '0;
               state_in = S_LINK;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_LINK: begin
            // pointer to the new table: base + page
            alu_req.op    = ptw_pkg::ALU_ADD;
            alu_req.a     = base_ff;
            alu_req.b     = ptw_pkg::PPN_W'(new_page);
            mem_req.we    = 1'b1;
            mem_req.wdata = {alu_res.sum, ptw_pkg::FLAGS_PTR};
            page_in       = new_page;
            nfp_in        = nfp_ff + 1'b1;
            level_in      = level_ff - 1'b1;
            state_in      = S_READ;
         end

         S_LEAF: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = leaf_pte;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ptw_pkg::ST_OK;
            rsp_pte_in    = leaf_pte;
            rsp_level_in  = '0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         nfp_ff       <= ptw_pkg::NFP_W'(1);
         sweep_ff     <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nfp_ff       <= nfp_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            base_ff <= csr_table_base_ppn;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pte_ff    <= rsp_pte_in;
      rsp_level_ff  <= rsp_level_in;
      if (start && !busy) begin
         op_ff     <= ptw_pkg::req_kind_type'(req_type);
         vpn_ff    <= req_virt_addr[ptw_pkg::VA_W-1:ptw_pkg::PG_SHIFT];
         pa_ppn_ff <= req_phys_addr[ptw_pkg::PA_W-1:ptw_pkg::PG_SHIFT];
         perm_ff   <= req_perm_flags;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pte_value   = rsp_pte_ff;
   assign rsp_found_level = rsp_level_ff;

   // failure results other than conflict carry no entry and level zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ptw_pkg::ST_OK) && (rsp_status != ptw_pkg::ST_CONFLICT))
      |-> ((rsp_pte_value == '0) && (rsp_found_level == '0)))
      else $error("failure transfer with nonzero entry or level");

   // the allocator never passes the store size
   assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= ptw_pkg::NFP_W'(ptw_pkg::TABLE_PAGES))
      else $error("page allocator overran the store");

   // a misaligned map answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == ptw_pkg::REQ_MAP) && misaligned)
      |=> (rsp_valid && (rsp_status == ptw_pkg::ST_MISALIGN)))
      else $error("misaligned map not answered at once");

   // no store write while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_req.we)
      else $error("store written while idle");

   // a walk never reports a level above the root
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found_level != 2'd3))
      else $error("found level out of range");

endmodule

`default_nettype wire
